/* design/led_chain_pulse_encoder_defines.svh */
// Assertion helpers shared by the encoder RTL.
`ifndef LED_CHAIN_PULSE_ENCODER_DEFINES_SVH
`define LED_CHAIN_PULSE_ENCODER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LCPE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define LCPE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/lcpe_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package lcpe_pkg;

   localparam int WORD_BITS_DEFAULT = 24;
   localparam int PIXEL_BITS        = 24;
   localparam int CSR_INDEX_BITS    = 3;
   localparam int CSR_DATA_BITS     = 16;

   localparam logic [7:0]  BIT_TICKS_RST       = 8'd5;
   localparam logic [7:0]  ONE_HIGH_TICKS_RST  = 8'd4;
   localparam logic [7:0]  ZERO_HIGH_TICKS_RST = 8'd2;
   localparam logic [15:0] RESET_TICKS_RST     = 16'h0300;
   localparam logic [15:0] LATCH_TICKS_RST     = 16'h0FFF;
   localparam logic        IDLE_LEVEL_RST      = 1'b1;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_BIT_TICKS       = 3'd0,
      CSR_ONE_HIGH_TICKS  = 3'd1,
      CSR_ZERO_HIGH_TICKS = 3'd2,
      CSR_RESET_TICKS     = 3'd3,
      CSR_LATCH_TICKS     = 3'd4,
      CSR_IDLE_LEVEL      = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_RESET = 2'd1,
      PH_DATA  = 2'd2,
      PH_LATCH = 2'd3
   } phase_type;

   typedef struct packed {
      logic                  mode;
      logic [PIXEL_BITS-1:0] pixel_word;
      logic                  last_of_frame;
   } req_type;

   typedef struct packed {
      logic line_level;
      logic ready_res;
      logic busy_res;
      logic underrun;
   } rsp_type;

endpackage
`default_nettype wire

/* design/led_chain_pulse_encoder.sv */
`timescale 1ns / 1ps
`default_nettype none
// An accepted word's result is registered in the output register, or in the skid on a stall.
// Throughput: one tick word per cycle while req_stall is low; the whole tick
// update is one pass of logic between the state registers and the result register.
// A two-deep result stage (output register plus skid) keeps req_stall registered.
// Reset (synchronous, active high): idle phase, empty holding buffer, registers at defaults.
module led_chain_pulse_encoder #(
   parameter int WORD_BITS = lcpe_pkg::WORD_BITS_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire lcpe_pkg::req_type                   req_data,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output lcpe_pkg::rsp_type                        rsp_data,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [lcpe_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [lcpe_pkg::CSR_DATA_BITS-1:0]  csr_data
);
   import lcpe_pkg::*;
`include "led_chain_pulse_encoder_defines.svh"

   localparam int BI_W = $clog2(WORD_BITS + 1);
   localparam logic [BI_W-1:0] BI_END = BI_W'(WORD_BITS);

   // ---------------------------------------------------------------------
   // Configuration registers. A write is seen from the next tick on; the
   // host must write only while no word is in flight; this is not enforced.
   // ---------------------------------------------------------------------
   logic [7:0]  bit_ticks_ff, one_high_ff, zero_high_ff;
   logic [15:0] reset_ticks_ff, latch_ticks_ff;
   logic        idle_level_ff;
   logic        csr_write;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid & csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_ticks_ff   <= BIT_TICKS_RST;
         one_high_ff    <= ONE_HIGH_TICKS_RST;
         zero_high_ff   <= ZERO_HIGH_TICKS_RST;
         reset_ticks_ff <= RESET_TICKS_RST;
         latch_ticks_ff <= LATCH_TICKS_RST;
         idle_level_ff  <= IDLE_LEVEL_RST;
      end else if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_BIT_TICKS:       bit_ticks_ff   <= csr_data[7:0];
            CSR_ONE_HIGH_TICKS:  one_high_ff    <= csr_data[7:0];
            CSR_ZERO_HIGH_TICKS: zero_high_ff   <= csr_data[7:0];
            CSR_RESET_TICKS:     reset_ticks_ff <= csr_data;
            CSR_LATCH_TICKS:     latch_ticks_ff <= csr_data;
            CSR_IDLE_LEVEL:      idle_level_ff  <= csr_data[0];
            default: ;           // unmapped index: dropped
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Encoder state
   // ---------------------------------------------------------------------
   phase_type              phase_ff, phase_in;
   logic [15:0]            tick_ff, tick_in;
   logic [BI_W-1:0]        bit_idx_ff, bit_idx_in;
   logic [WORD_BITS-1:0]   shift_ff, shift_in;
   logic [PIXEL_BITS-1:0]  held_word_ff, held_word_in;
   logic                   held_valid_ff, held_valid_in;
   logic                   held_last_ff, held_last_in;
   logic                   cur_last_ff, cur_last_in;
   logic [WORD_BITS-1:0]   held_ext;
   rsp_type                step_rsp;
   logic                   req_take;

   // Holding word widened/trimmed to the serial word length.
   for (genvar g = 0; g < WORD_BITS; g++) begin : g_ext
      if (g < PIXEL_BITS) begin : g_bit
         assign held_ext[g] = held_word_in[g];
      end else begin : g_zero
         assign held_ext[g] = 1'b0;
      end
   end

   assign req_take = req_valid & ~req_stall;

   // One tick of the line code. Phases may fall through within the tick:
   // idle -> reset -> data, and data -> latch -> idle for zero-length gaps.
   always_comb begin
      logic [7:0] blen;
      logic [7:0] high_t;
      logic       accept_word;

      blen        = (bit_ticks_ff == 8'd0) ? 8'd1 : bit_ticks_ff;
      accept_word = req_data.mode & ~held_valid_ff;

      phase_in      = phase_ff;
      tick_in       = tick_ff;
      bit_idx_in    = bit_idx_ff;
      shift_in      = shift_ff;
      held_word_in  = accept_word ? req_data.pixel_word : held_word_ff;
      held_valid_in = held_valid_ff | accept_word;
      held_last_in  = accept_word ? req_data.last_of_frame : held_last_ff;
      cur_last_in   = cur_last_ff;
      step_rsp      = '{line_level: 1'b0, ready_res: accept_word,
                        busy_res: 1'b1, underrun: 1'b0};

      if (phase_in == PH_IDLE && held_valid_in) begin
         phase_in = PH_RESET;
         tick_in  = '0;
      end
      if (phase_in == PH_RESET && tick_in >= reset_ticks_ff) begin
         shift_in      = held_ext;
         cur_last_in   = held_last_in;
         held_valid_in = 1'b0;
         bit_idx_in    = '0;
         tick_in       = '0;
         phase_in      = PH_DATA;
      end
      if (phase_in == PH_DATA) begin
         if (bit_idx_in < BI_END && tick_in >= {8'd0, blen}) begin
            bit_idx_in = bit_idx_in + BI_W'(1);
            tick_in    = '0;
            shift_in   = {shift_in[WORD_BITS-2:0], 1'b0};
         end
         if (bit_idx_in >= BI_END) begin
            if (cur_last_in) begin
               phase_in = PH_LATCH;
               tick_in  = '0;
            end else if (held_valid_in) begin
               shift_in      = held_ext;
               cur_last_in   = held_last_in;
               held_valid_in = 1'b0;
               bit_idx_in    = '0;
               tick_in       = '0;
            end
         end
      end
      if (phase_in == PH_LATCH && tick_in >= latch_ticks_ff) begin
         phase_in = PH_IDLE;
      end

      // Output for this tick
      high_t = shift_in[WORD_BITS-1] ? one_high_ff : zero_high_ff;
      case (phase_in)
         PH_IDLE: begin
            step_rsp.line_level = idle_level_ff;
            step_rsp.busy_res   = 1'b0;
         end
         PH_DATA: begin
            if (bit_idx_in >= BI_END) begin
               step_rsp.underrun = 1'b1;   // starved mid-frame: hold line low
            end else begin
               step_rsp.line_level = (tick_in < {8'd0, high_t});
               tick_in             = tick_in + 16'd1;
            end
         end
         default: begin
            tick_in = tick_in + 16'd1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         tick_ff       <= '0;
         bit_idx_ff    <= '0;
         shift_ff      <= '0;
         held_valid_ff <= 1'b0;
         held_last_ff  <= 1'b0;
         cur_last_ff   <= 1'b0;
      end else if (req_take) begin
         phase_ff      <= phase_in;
         tick_ff       <= tick_in;
         bit_idx_ff    <= bit_idx_in;
         shift_ff      <= shift_in;
         held_valid_ff <= held_valid_in;
         held_last_ff  <= held_last_in;
         cur_last_ff   <= cur_last_in;
      end
   end

   // holding word has no reset: only read after a write
   always_ff @(posedge clock) begin
      if (req_take) begin
         held_word_ff <= held_word_in;
      end
   end

   // ---------------------------------------------------------------------
   // Result stage: output register plus a one-word skid. req_stall comes
   // straight from the skid flag, so it never waits on rsp_stall.
   // ---------------------------------------------------------------------
   logic    out_valid_ff, skid_valid_ff;
   rsp_type out_data_ff, skid_data_ff;
   logic    out_free;

   assign out_free  = ~out_valid_ff | ~rsp_stall;
   assign req_stall = skid_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff  <= skid_valid_ff | req_take;
         skid_valid_ff <= 1'b0;
      end else if (req_take) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         out_data_ff <= skid_valid_ff ? skid_data_ff : step_rsp;
      end else if (req_take) begin
         skid_data_ff <= step_rsp;
      end
   end

   // ---------------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------------
   `LCPE_ASSERT_NOW(a_skid_behind_out, clock, reset, skid_valid_ff, out_valid_ff,
                    "skid full with empty output")
   `LCPE_ASSERT_NEXT(a_take_gives_rsp, clock, reset, req_take, out_valid_ff,
                     "accepted word produced no result")
   `LCPE_ASSERT_NOW(a_data_index, clock, reset, phase_ff == PH_DATA, bit_idx_ff <= BI_END,
                    "bit index past word end")
   `LCPE_ASSERT_NOW(a_underrun_low, clock, reset, out_valid_ff && out_data_ff.underrun,
                    !out_data_ff.line_level && out_data_ff.busy_res,
                    "underrun with line high or not busy")

endmodule
`default_nettype wire
